>>> rtl/core/moving_average_filter_defines.svh
// Assertion macros shared by the moving average filter RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef MOVING_AVERAGE_FILTER_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_DEFINES_SVH

// Clocked assertion with explicit clock and active-low reset.
`define MAF_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block's own clock and reset.
`define MAF_ASSERT(lbl, prop, msg) \
  `MAF_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/core/maf_pkg.sv
// Package for the moving average filter: sizes, state encoding, history request.
// Depends on nothing.
`timescale 1ns / 1ps
package maf_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 7;
  localparam int PTR_W       = $clog2(MAX_WINDOW);
  localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
  localparam int TOTAL_W     = SAMPLE_BITS + PTR_W;
  localparam int CNT_W       = $clog2(TOTAL_W + 1);
  localparam int LEN_RESET   = (MAX_WINDOW < 8) ? MAX_WINDOW : 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE
  } maf_state_e;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [PTR_W-1:0] addr;
  } hist_req_t;

endpackage

>>> rtl/core/maf_history.sv
// Sample history: single-port memory with per-entry valid bits.
// Depends on maf_pkg. Entries not written since clear read as zero.
`timescale 1ns / 1ps
module maf_history (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clear_i,
  input  maf_pkg::hist_req_t                   req_i,
  input  logic signed [maf_pkg::SAMPLE_BITS-1:0] wr_data_i,
  output logic signed [maf_pkg::SAMPLE_BITS-1:0] rd_data_o
);
  import maf_pkg::*;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]         valid_q, valid_d;
  logic signed [SAMPLE_BITS-1:0] rd_data_q;
  logic                          rd_valid_q;

  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = '0;
    end else if (req_i.wr_en) begin
      valid_d[req_i.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.addr];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

>>> rtl/core/maf_divider.sv
// Serial signed divider: one quotient bit per cycle, truncating toward zero.
// Depends on maf_pkg. Divisor is the window length, never zero.
`timescale 1ns / 1ps
module maf_divider (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [maf_pkg::TOTAL_W-1:0]    dividend_i,
  input  logic [maf_pkg::LEN_W-1:0]             divisor_i,
  output logic                                  done_o,
  output logic signed [maf_pkg::SAMPLE_BITS-1:0] quotient_o
);
  import maf_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 neg_q, neg_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [TOTAL_W-1:0]   quo_q, quo_d;
  logic [LEN_W-1:0]     rem_q, rem_d;
  logic [LEN_W-1:0]     div_q, div_d;
  logic [LEN_W:0]       rem_sh;
  logic [LEN_W:0]       rem_sub;
  logic                 fits;
  logic [SAMPLE_BITS-1:0] mag;

  always_comb begin
    busy_d  = busy_q;
    done_d  = done_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    rem_sh  = {rem_q, quo_q[TOTAL_W-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    fits    = (rem_sh >= {1'b0, div_q});
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      neg_d  = dividend_i[TOTAL_W-1];
      quo_d  = dividend_i[TOTAL_W-1] ? TOTAL_W'(-dividend_i) : TOTAL_W'(dividend_i);
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = CNT_W'(TOTAL_W);
    end else if (busy_q) begin
      quo_d = {quo_q[TOTAL_W-2:0], fits};
      rem_d = fits ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign mag        = quo_q[SAMPLE_BITS-1:0];
  assign quotient_o = neg_q ? -mag : mag;
  assign done_o     = done_q;

endmodule

>>> rtl/core/moving_average_filter.sv
// Moving average filter top level: sequencer, running total, output register.
// A sample transaction passes through states UPDATE, START and DIVIDE before the result is
// registered; the one-bit-per-cycle divider sets the pace, and one sample is in flight at a time.
// A new sample is taken only back in IDLE; DIVIDE waits while the result side holds the output.
// Reset clears history valid bits, total and pointer, and loads window length 8.
`timescale 1ns / 1ps
`include "moving_average_filter_defines.svh"
module moving_average_filter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [maf_pkg::CFG_W-1:0]             cfg_wdata_i,
  input  logic                                  sample_valid_i,
  output logic                                  sample_ready_o,
  input  logic signed [maf_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                  average_valid_o,
  input  logic                                  average_ready_i,
  output logic signed [maf_pkg::SAMPLE_BITS-1:0] average_o
);
  import maf_pkg::*;

  maf_state_e                    st_q, st_d;
  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [PTR_W-1:0]              pos_q, pos_d;
  logic [PTR_W-1:0]              wr_pos_q, wr_pos_d;
  logic [LEN_W-1:0]              len_q, len_d;
  logic signed [TOTAL_W-1:0]     total_q, total_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] average_q, average_d;

  hist_req_t                     hist_req;
  logic signed [SAMPLE_BITS-1:0] leaving;
  logic                          div_start;
  logic                          div_done;
  logic signed [SAMPLE_BITS-1:0] quotient;
  logic                          in_accept;
  logic                          out_load;
  logic [PTR_W-1:0]              pos_sel;
  logic [LEN_W-1:0]              pos_inc;

  maf_history u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_we_i),
    .req_i     (hist_req),
    .wr_data_i (sample_q),
    .rd_data_o (leaving)
  );

  maf_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_q),
    .divisor_i  (len_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    st_d        = st_q;
    sample_d    = sample_q;
    pos_d       = pos_q;
    wr_pos_d    = wr_pos_q;
    len_d       = len_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    average_d   = average_q;
    div_start   = 1'b0;
    out_load    = 1'b0;

    sample_ready_o = (st_q == ST_IDLE);
    in_accept      = sample_valid_i && sample_ready_o;
    pos_sel        = (LEN_W'(wr_pos_q) >= len_q) ? '0 : wr_pos_q;
    pos_inc        = LEN_W'(pos_q) + LEN_W'(1);

    hist_req.rd_en = in_accept;
    hist_req.wr_en = (st_q == ST_UPDATE);
    hist_req.addr  = in_accept ? pos_sel : pos_q;

    if (out_valid_q && average_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (in_accept) begin
          sample_d = sample_i;
          pos_d    = pos_sel;
          st_d     = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        total_d  = total_q + TOTAL_W'(sample_q) - TOTAL_W'(leaving);
        wr_pos_d = (pos_inc >= len_q) ? '0 : pos_inc[PTR_W-1:0];
        st_d     = ST_START;
      end
      ST_START: begin
        div_start = 1'b1;
        st_d      = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done && (!out_valid_q || average_ready_i)) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          average_d   = quotient;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      wr_pos_d = '0;
      total_d  = '0;
      if (cfg_wdata_i == '0) begin
        len_d = LEN_W'(1);
      end else if (32'(cfg_wdata_i) > 32'(MAX_WINDOW)) begin
        len_d = LEN_W'(MAX_WINDOW);
      end else begin
        len_d = LEN_W'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      wr_pos_q    <= '0;
      len_q       <= LEN_W'(LEN_RESET);
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      wr_pos_q    <= wr_pos_d;
      len_q       <= len_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    pos_q     <= pos_d;
    average_q <= average_d;
  end

  assign average_valid_o = out_valid_q;
  assign average_o       = average_q;

  `MAF_ASSERT(a_accept_to_update, in_accept |=> (st_q == ST_UPDATE), "accept did not start update")
  `MAF_ASSERT(a_wr_pos_in_window, (LEN_W'(wr_pos_q) < len_q), "write pointer outside window")
  `MAF_ASSERT(a_hist_single_port, !(hist_req.rd_en && hist_req.wr_en), "history port conflict")
  `MAF_ASSERT(a_load_sets_valid, out_load |=> out_valid_q, "result load lost")

endmodule

>>> test/testbench.sv
// Testbench for moving_average_filter: sample stream against a predicted mean per transaction.
// Depends on maf_pkg for sizes and on the moving_average_filter RTL.
`timescale 1ns / 1ps
module testbench;
  import maf_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam int SETTLE_CYCLES = TOTAL_W + 8;

  class average_scoreboard;
    sample_t     history[MAX_WINDOW];
    int unsigned wr_pos;
    int unsigned win_len;
    int          running_total;
    sample_t     expected_avg[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      win_len = LEN_RESET;
      clear_history();
    endfunction

    function void clear_history();
      for (int i = 0; i < MAX_WINDOW; i++) history[i] = '0;
      wr_pos = 0;
      running_total = 0;
    endfunction

    function void set_length(logic [CFG_W-1:0] value);
      if (value == 0) win_len = 1;
      else if (value > MAX_WINDOW) win_len = MAX_WINDOW;
      else win_len = 32'(value);
      clear_history();
    endfunction

    function void note_sample(sample_t s);
      int leaving;
      int mean;
      if (wr_pos >= win_len) wr_pos = 0;
      leaving = int'(history[wr_pos]);
      history[wr_pos] = s;
      running_total = running_total + int'(s) - leaving;
      wr_pos++;
      if (wr_pos >= win_len) wr_pos = 0;
      mean = running_total / int'(win_len);
      expected_avg.push_back(mean[SAMPLE_BITS-1:0]);
    endfunction

    function void check_average(sample_t actual);
      sample_t want;
      if (expected_avg.size() == 0) begin
        $display("%0t: unexpected average %0d, nothing pending", $time, actual);
        mismatches++;
      end else begin
        want = expected_avg.pop_front();
        if (actual !== want) begin
          $display("%0t: average mismatch, expected %0d, actual %0d", $time, want, actual);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_avg.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             sample_valid_i;
  logic             sample_ready_o;
  sample_t          sample_i;
  logic             average_valid_o;
  logic             average_ready_i;
  sample_t          average_o;

  average_scoreboard board;
  bit                calm;
  int unsigned       results_seen;
  int unsigned       stall_left;

  moving_average_filter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .sample_valid_i  (sample_valid_i),
    .sample_ready_o  (sample_ready_o),
    .sample_i        (sample_i),
    .average_valid_o (average_valid_o),
    .average_ready_i (average_ready_i),
    .average_o       (average_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t random_sample();
    int unsigned r;
    sample_t s;
    r = $urandom_range(0, 9);
    if (r < 5) s = sample_t'($urandom);
    else if (r < 7) s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
    else if (r < 8) s = sample_t'($signed($urandom_range(0, 8)) - 4);
    else if (r < 9) s = SAMPLE_MAX - sample_t'($urandom_range(0, 3));
    else s = SAMPLE_MIN + sample_t'($urandom_range(0, 3));
    return s;
  endfunction

  // Call at a rising edge; returns at the edge that accepts the transaction.
  task automatic send_sample(sample_t s);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      sample_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= s;
    do @(posedge clk_i); while (!sample_ready_o);
    board.note_sample(s);
  endtask

  task automatic drain_results();
    sample_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window_length(logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_length(value);
  endtask

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random back-pressure plus two long hold-offs.
  initial begin
    average_ready_i = 1'b0;
    results_seen = 0;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (average_valid_o && average_ready_i) begin
        board.check_average(average_o);
        results_seen++;
        if (results_seen == 150 || results_seen == 500) stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        average_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = pick_gap();
        average_ready_i <= (stall_left == 0);
      end else begin
        average_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    sample_t          directed[$];
    logic [CFG_W-1:0] lengths[$];
    logic [CFG_W-1:0] len_val;
    int unsigned      win;
    int unsigned      count;
    sample_t          s;

    board          = new();
    calm           = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    sample_valid_i = 1'b0;
    sample_i       = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window: partial fill, full-scale windows, rounding toward zero.
    repeat (8) directed.push_back(SAMPLE_MAX);
    repeat (8) directed.push_back(SAMPLE_MIN);
    directed.push_back(sample_t'(-1));
    directed.push_back(sample_t'(1));
    directed.push_back(sample_t'(0));
    directed.push_back(sample_t'(16'h5555));
    directed.push_back(sample_t'(16'haaaa));
    directed.push_back(sample_t'(-3));
    directed.push_back(sample_t'(7));
    foreach (directed[i]) send_sample(directed[i]);
    drain_results();

    lengths = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd3, 7'd100, 7'd5, 7'd8};
    repeat (3) lengths.insert($urandom_range(1, lengths.size() - 1),
                              CFG_W'($urandom_range(0, 127)));

    foreach (lengths[p]) begin
      len_val = lengths[p];
      write_window_length(len_val);
      win = (len_val == 0) ? 1 : (len_val > MAX_WINDOW) ? MAX_WINDOW : len_val;
      count = (win >= 33) ? 80 : 40;
      calm = (p % 4 == 1);
      for (int i = 0; i < count; i++) begin
        if (p % 3 == 0 && i < win) s = (p % 2) ? SAMPLE_MIN : SAMPLE_MAX;
        else s = random_sample();
        send_sample(s);
      end
      drain_results();
    end
    calm = 1'b0;

    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/maf_pkg.sv
rtl/core/maf_history.sv
rtl/core/maf_divider.sv
rtl/core/moving_average_filter.sv
test/testbench.sv
